>>> hdl/lpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_pkg: shared types and constants of the light pattern animator
// Time format, item kinds, sequencer states and the style table entry.
// ----------------------------------------------------------------------------
package lpa_pkg;

  // Time in 1/65536 second units, wrapping modulo 2^48
  localparam int TIME_W    = 48;
  localparam int FRAC_W    = 16;
  localparam int RATE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int LEVEL_W   = 9;
  localparam int RATE_RESET = 10;

  // Elapsed (47 magnitude bits) times rate, then the frame count after the shift
  localparam int PROD_W    = TIME_W - 1 + RATE_W;
  localparam int FRAME_W   = 40;
  localparam int STEP_BITS = 4;
  localparam int DIV_STEPS = FRAME_W / STEP_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Stored level is the character minus 'a'
  localparam logic [LEVEL_W-1:0] LETTER_BASE = 9'd97;

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_PAT,
    S_OUT
  } lpa_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } style_entry_t;

endpackage

>>> hdl/light_pattern_animator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pattern_animator_top: animated light style levels
// A tick walks every style and reports its current pattern level through one
// shared multiplier and a 4-bit-per-cycle restoring modulo unit.
// Write and set transactions finish at the accepting edge; a tick keeps busy high
//   until every style is walked, so no new command is accepted during the walk.
// Per style the walk does: read, difference, multiply, 10 modulo steps, pattern
//   read, emit.
// Results are presented once each, one per style; the receiver cannot stall.
// Reset clears time and all style valid bits (lengths then read as zero), sets rate to 10; patterns stay unwritten.
// ----------------------------------------------------------------------------
module light_pattern_animator_top #(
  parameter int STYLE_COUNT      = 64,
  parameter int PATTERN_CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [15:0] style,
  input  logic [5:0]         position,
  input  logic [7:0]         letter,
  input  logic [5:0]         length,
  input  logic signed [31:0] start_offset,
  input  logic [31:0]        time_delta,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  // result channel
  output logic               result_valid,
  output logic [5:0]         style_index,
  output logic signed [8:0]  level,
  output logic               last
);
  import lpa_pkg::*;

  localparam int SW = (STYLE_COUNT > 1) ? $clog2(STYLE_COUNT) : 1;
  localparam int PW = (PATTERN_CAPACITY > 1) ? $clog2(PATTERN_CAPACITY) : 1;
  localparam int AW = SW + PW;

  lpa_state_t state, state_next;

  logic [RATE_W-1:0]  anim_rate;
  logic [TIME_W-1:0]  now_time;

  // style table with per-entry valid bits, pattern memory without
  style_entry_t       style_mem [STYLE_COUNT];
  logic [STYLE_COUNT-1:0] style_vld;
  style_entry_t       style_rd;
  logic               style_rd_vld;
  logic [LEVEL_W-1:0] pat_mem [2**AW];
  logic [LEVEL_W-1:0] pat_rd;

  // walk datapath
  logic [SW-1:0]      cnt;
  logic [TIME_W-1:0]  elapsed;
  logic [LEN_W-1:0]   cur_len;
  logic [FRAME_W-1:0] frame;
  logic [LEN_W-1:0]   rem;
  logic [DCNT_W-1:0]  dcnt;
  logic [PROD_W-1:0]  prod;
  logic [FRAME_W-1:0] frame_next;
  logic [LEN_W-1:0]   rem_next;

  logic               accept;
  logic [SW-1:0]      st_sel;
  logic [LEN_W-1:0]   len_sat;
  logic               last_style;

  assign accept     = start && !busy;
  assign busy       = (state != S_IDLE);
  assign cfg_ready  = !busy;
  assign last_style = (cnt == SW'(STYLE_COUNT - 1));

  // clamp the style index into the table
  always_comb begin
    if (style[15]) begin
      st_sel = '0;
    end else if (style > 16'(STYLE_COUNT - 1)) begin
      st_sel = SW'(STYLE_COUNT - 1);
    end else begin
      st_sel = SW'(style);
    end
  end

  // saturate the length below the pattern capacity
  always_comb begin
    if (32'(length) > PATTERN_CAPACITY - 1) begin
      len_sat = LEN_W'(PATTERN_CAPACITY - 1);
    end else begin
      len_sat = length;
    end
  end

  // rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      anim_rate <= RATE_W'(RATE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      anim_rate <= cfg_data;
    end
  end

  // running time: advance on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= '0;
    end else if (accept && kind == KIND_TICK) begin
      now_time <= now_time + TIME_W'(time_delta);
    end
  end

  // style table: write on set, read during the walk
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_SET) begin
      style_mem[st_sel] <= '{start: now_time + TIME_W'(start_offset), len: len_sat};
    end
    if (state == S_READ) begin
      style_rd <= style_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      style_vld    <= '0;
      style_rd_vld <= 1'b0;
    end else begin
      if (accept && kind == KIND_SET) begin
        style_vld[st_sel] <= 1'b1;
      end
      if (state == S_READ) begin
        style_rd_vld <= style_vld[cnt];
      end
    end
  end

  // pattern memory: write a letter, read the selected frame
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WRITE && 32'(position) < PATTERN_CAPACITY) begin
      pat_mem[AW'({st_sel, PW'(position)})] <= {1'b0, letter} - LETTER_BASE;
    end
    if (state == S_PAT) begin
      pat_rd <= pat_mem[AW'({cnt, PW'(rem)})];
    end
  end

  // shared multiplier: elapsed times rate
  assign prod = PROD_W'(elapsed[TIME_W-2:0]) * PROD_W'(anim_rate);

  // modulo unit: four restoring steps per cycle
  always_comb begin
    logic [LEN_W:0]     t;
    logic [LEN_W-1:0]   r;
    logic [FRAME_W-1:0] f;
    r = rem;
    f = frame;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, f[FRAME_W-1]};
      f = {f[FRAME_W-2:0], 1'b0};
      if (t >= {1'b0, cur_len}) begin
        t = t - {1'b0, cur_len};
      end
      r = t[LEN_W-1:0];
    end
    rem_next   = r;
    frame_next = f;
  end

  // walk datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_DIFF: begin
        elapsed <= now_time - style_rd.start;
        cur_len <= style_rd_vld ? style_rd.len : '0;
      end
      S_MUL: begin
        // negative elapsed time counts as frame 0
        frame <= elapsed[TIME_W-1] ? '0 : FRAME_W'(prod[PROD_W-1:FRAC_W]);
        rem   <= '0;
      end
      S_DIV: begin
        frame <= frame_next;
        rem   <= rem_next;
      end
      default: begin
      end
    endcase
  end

  // style and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      dcnt <= '0;
    end else begin
      if (accept && kind == KIND_TICK) begin
        cnt <= '0;
      end else if (state == S_OUT) begin
        cnt <= SW'(cnt + 1'b1);
      end
      if (state == S_MUL) begin
        dcnt <= '0;
      end else if (state == S_DIV) begin
        dcnt <= DCNT_W'(dcnt + 1'b1);
      end
    end
  end

  // result register: one strobe per style
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      style_index <= 6'(cnt);
      level       <= (cur_len == '0) ? '0 : pat_rd;
      last        <= last_style;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && kind == KIND_TICK) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_DIFF;
      S_DIFF: state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
          state_next = S_PAT;
        end
      end
      S_PAT:  state_next = S_OUT;
      S_OUT:  state_next = last_style ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

endmodule
